// File: sv/dkt_pkg.sv
// Package for the dictionary key tokenizer: sizes, key state type and stop-word table.
// No dependencies. Used by the interfaces, dkt_stop_match and the top level.
`default_nettype none

package dkt_pkg;

  localparam int KeyLimit    = 32;
  localparam int PosW        = 24;
  localparam int UnitW       = 16;
  localparam int LenW        = 6;
  localparam int PrefixDepth = 6;
  localparam int StopCount   = 32;

  typedef logic [UnitW-1:0] unit_t;
  typedef logic [LenW-1:0]  len_t;

  // Open-key state as seen by the stop-word matcher.
  typedef struct packed {
    len_t                         len;
    logic [PrefixDepth-1:0][UnitW-1:0] prefix;
  } key_t;

  typedef struct packed {
    logic [2:0]       len;
    logic [0:5][7:0]  txt;
  } stop_word_t;

  localparam stop_word_t StopWords [StopCount] = '{
    '{3'd4, {"abbr", 16'h0}}, '{3'd3, {"col", 24'h0}}, '{3'd3, {"vul", 24'h0}},
    '{3'd4, {"vulg", 16'h0}}, '{3'd4, {"then", 16'h0}}, '{3'd3, {"and", 24'h0}},
    '{3'd4, {"conj", 16'h0}}, '{3'd3, {"int", 24'h0}}, '{3'd4, {"pron", 16'h0}},
    '{3'd3, {"suf", 24'h0}},  '{3'd3, {"syn", 24'h0}}, '{3'd3, {"ant", 24'h0}},
    '{3'd4, {"from", 16'h0}}, '{3'd3, {"adv", 24'h0}}, '{3'd3, {"adj", 24'h0}},
    '{3'd3, {"hon", 24'h0}},  '{3'd3, {"hum", 24'h0}}, '{3'd3, {"pol", 24'h0}},
    '{3'd6, "adj-na"},        '{3'd6, "adj-no"},       '{3'd6, "adj-pn"},
    '{3'd5, {"v5aru", 8'h0}}, '{3'd3, {"v5b", 24'h0}}, '{3'd3, {"v5g", 24'h0}},
    '{3'd3, {"v5k", 24'h0}},  '{3'd5, {"v5k-s", 8'h0}}, '{3'd3, {"v5m", 24'h0}},
    '{3'd3, {"v5r", 24'h0}},  '{3'd3, {"v5s", 24'h0}}, '{3'd3, {"v5t", 24'h0}},
    '{3'd3, {"v5u", 24'h0}},  '{3'd3, {"etc", 24'h0}}
  };

endpackage

`default_nettype wire

// File: sv/dkt_if.sv
// Stream interfaces for the tokenizer: text-unit input channel and key output channel.
// Depends on dkt_pkg.
`default_nettype none

interface dkt_in_if
  import dkt_pkg::*;
;
  logic  valid;
  logic  ready;
  unit_t code_unit;
  logic  end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface dkt_out_if
  import dkt_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PosW-1:0] start_position;

  modport source (output valid, output start_position, input ready);
  modport sink   (input valid, input start_position, output ready);
endinterface

`default_nettype wire

// File: sv/dkt_stop_match.sv
// Parallel compare of the open key against the fixed stop-word table.
// Depends on dkt_pkg.
`default_nettype none

module dkt_stop_match
  import dkt_pkg::*;
(
  input  key_t key_i,
  output logic hit_o
);

  logic [StopCount-1:0] hit;

  always_comb begin
    for (int j = 0; j < StopCount; j++) begin
      hit[j] = (key_i.len == {3'b000, StopWords[j].len});
      for (int k = 0; k < PrefixDepth; k++) begin
        // only entries below the word length take part
        if (k < int'(StopWords[j].len)) begin
          if (key_i.prefix[k] != {8'h00, StopWords[j].txt[k]}) begin
            hit[j] = 1'b0;
          end
        end
      end
    end
  end

  assign hit_o = |hit;

endmodule

`default_nettype wire

// File: sv/dictionary_key_tokenizer_top.sv
// Dictionary key tokenizer top level: input register, key scanner, result register + skid.
// Depends on dkt_pkg, dkt_if.sv (dkt_in_if, dkt_out_if) and dkt_stop_match.
// Path: input register, then key scanner; a closing unit registers the key start in out or skid.
// Throughput: one unit per cycle while the skid slot is free; the key state updates once per unit.
// Backpressure: a two-entry output (register + skid) keeps input flowing while a beat waits.
// Reset (rst_ni low, async): no open key, position 0, all pipeline valids cleared.
`default_nettype none

module dictionary_key_tokenizer_top
  import dkt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dkt_in_if.sink     in_i,
  dkt_out_if.source  out_o
);

  // ASCII letter test
  function automatic logic is_letter(unit_t c);
    is_letter = (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A);
  endfunction

  // unit may open a key: letter or above 0x3000
  function automatic logic can_open(unit_t c);
    can_open = is_letter(c) || (c > 16'h3000);
  endfunction

  // unit may continue a key: letter, digit, '-', '.', or above 255
  function automatic logic can_extend(unit_t c);
    can_extend = is_letter(c) || (c > 16'h00FF) || (c == 16'h002D) || (c == 16'h002E) ||
                 (c >= 16'h0030 && c <= 16'h0039);
  endfunction

  // ---------------------------------------------------------------------------
  // Input register. Advances whenever it holds a unit and the skid slot is free, so at
  // most one result can land in the output stage per cycle without overflow.
  // ---------------------------------------------------------------------------
  logic  s1_valid_q, s1_valid_d;
  unit_t s1_unit_q;
  logic  s1_eot_q;
  logic  in_fire, advance;

  logic  skid_valid_q, skid_valid_d;

  assign advance     = s1_valid_q && !skid_valid_q;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_unit_q <= in_i.code_unit;
      s1_eot_q  <= in_i.end_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // Key scanner state
  // ---------------------------------------------------------------------------
  logic            in_key_q, in_key_d;
  len_t            key_len_q, key_len_d;
  logic [PosW-1:0] key_start_q, key_start_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PrefixDepth-1:0][UnitW-1:0] prefix_q, prefix_d;

  key_t key;
  logic stop_hit;
  logic emit;

  assign key.len    = key_len_q;
  assign key.prefix = prefix_q;

  dkt_stop_match u_stop_match (
    .key_i (key),
    .hit_o (stop_hit)
  );

  always_comb begin
    in_key_d    = in_key_q;
    key_len_d   = key_len_q;
    key_start_d = key_start_q;
    pos_d       = pos_q;
    prefix_d    = prefix_q;
    emit        = 1'b0;
    if (advance) begin
      if (!in_key_q) begin
        if (can_open(s1_unit_q)) begin
          prefix_d[0] = s1_unit_q;
          key_len_d   = len_t'(1);
          key_start_d = pos_q;
          in_key_d    = 1'b1;
        end
      end else if (can_extend(s1_unit_q)) begin
        // only the first few units are kept for the stop-word compare
        if (key_len_q < len_t'(PrefixDepth)) begin
          prefix_d[key_len_q[2:0]] = s1_unit_q;
        end
        if (key_len_q < len_t'(KeyLimit)) begin
          key_len_d = key_len_q + len_t'(1);
        end
      end else begin
        // closing unit: non-ASCII-led keys always pass
        emit      = (prefix_q[0] >= 16'h0080) ||
                    ((key_len_q > len_t'(2)) && !stop_hit);
        in_key_d  = 1'b0;
        key_len_d = '0;
      end
      pos_d = pos_q + PosW'(1);
      if (s1_eot_q) begin
        in_key_d  = 1'b0;
        key_len_d = '0;
        pos_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_key_q    <= 1'b0;
      key_len_q   <= '0;
      key_start_q <= '0;
      pos_q       <= '0;
    end else begin
      in_key_q    <= in_key_d;
      key_len_q   <= key_len_d;
      key_start_q <= key_start_d;
      pos_q       <= pos_d;
    end
  end

  // prefix entries are only read once written for the current key
  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
  end

  // ---------------------------------------------------------------------------
  // Output register + skid slot
  // ---------------------------------------------------------------------------
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] out_pos_q, out_pos_d;
  logic [PosW-1:0] skid_pos_q, skid_pos_d;
  logic            out_fire;

  assign out_fire = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_pos_d    = out_pos_q;
    skid_valid_d = skid_valid_q;
    skid_pos_d   = skid_pos_q;
    if (skid_valid_q) begin
      // no new results while the skid is full
      if (out_fire) begin
        out_valid_d  = 1'b1;
        out_pos_d    = skid_pos_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = emit;
      out_pos_d   = key_start_q;
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_pos_d   = key_start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q  <= out_pos_d;
    skid_pos_q <= skid_pos_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.start_position = out_pos_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_len_tracks_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_key_q == (key_len_q != '0))
    else $error("key length and open-key flag disagree");

  a_len_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= len_t'(KeyLimit))
    else $error("key length beyond limit");

  a_eot_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_eot_q) |=> (!in_key_q && pos_q == '0))
    else $error("end of text did not clear key and position");

  a_emit_needs_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (in_key_q && advance))
    else $error("key start emitted without an open key");

endmodule

`default_nettype wire
